// ===== rtl/page_bitmap_blitter_assert.svh =====
// Assertion macros of the page bitmap blitter, included by the back end.
`ifndef PAGE_BITMAP_BLITTER_ASSERT_SVH
`define PAGE_BITMAP_BLITTER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PBB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// An implication checked in the same cycle.
`define PBB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbb_pkg.sv =====
// Shared types, constants and helpers of the page bitmap blitter.
`timescale 1ns / 1ps
package pbb_pkg;

    localparam int COORD_BITS = 10;
    localparam int PIX_BITS   = 10;
    localparam int FIFO_DEPTH = 4;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [PIX_BITS-1:0]   t_pix;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_NEXT  = 2'd2
    } t_action;

    // One nonzero bitmap byte placed on the screen, handed from front to back.
    typedef struct packed {
        t_coord      px;
        t_coord      py0;
        logic [7:0]  bits;
    } t_job;

    // Fit a 10-bit input coordinate into the internal coordinate width.
    function automatic t_coord to_coord(input logic [PIX_BITS-1:0] v);
        logic [COORD_BITS+PIX_BITS-1:0] w;
        w = {{COORD_BITS{1'b0}}, v};
        return w[COORD_BITS-1:0];
    endfunction

    // Fit an internal coordinate into the 10-bit output field.
    function automatic t_pix to_pix(input t_coord c);
        logic [COORD_BITS+PIX_BITS-1:0] w;
        w = {{PIX_BITS{1'b0}}, c};
        return w[PIX_BITS-1:0];
    endfunction

endpackage

// ===== rtl/pbb_fifo.sv =====
// Short job queue between the classifying front and the pixel back end.
`timescale 1ns / 1ps
module pbb_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  pbb_pkg::t_job i_job,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output pbb_pkg::t_job o_job
);
    import pbb_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

    t_job              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

// ===== rtl/pbb_front.sv =====
// Front end: takes words, keeps the image geometry and queues nonzero bytes.
`timescale 1ns / 1ps
module pbb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pbb_pkg::t_action i_action,
    input  logic [9:0]       i_start_x,
    input  logic [9:0]       i_start_y,
    input  logic [7:0]       i_image_width,
    input  logic [7:0]       i_image_height,
    input  logic [7:0]       i_bitmap_byte,
    output logic             o_push,
    output pbb_pkg::t_job    o_job,
    input  logic             i_full
);
    import pbb_pkg::*;

    localparam int SUM_W = COORD_BITS + 9;

    t_coord      r_origin_x, n_origin_x;
    t_coord      r_origin_y, n_origin_y;
    logic [7:0]  r_width,    n_width;
    logic [5:0]  r_pages,    n_pages;
    logic [7:0]  r_col,      n_col;
    logic [5:0]  r_page,     n_page;
    logic        r_active,   n_active;

    logic             accept;
    logic [SUM_W-1:0] px_sum, py_sum, nx_sum;
    logic [8:0]       h_round;
    logic [5:0]       new_pages;
    logic [7:0]       col_inc;
    logic [5:0]       page_inc;

    assign accept = i_valid && !i_full;
    assign o_ready = !i_full;

    assign px_sum = {9'd0, r_origin_x} + {{(COORD_BITS + 1){1'b0}}, r_col};
    assign py_sum = {9'd0, r_origin_y} + {{COORD_BITS{1'b0}}, r_page, 3'b000};
    assign nx_sum = {9'd0, r_origin_x} + {{(COORD_BITS + 1){1'b0}}, r_width}
                    + SUM_W'(1);
    assign h_round   = {1'b0, i_image_height} + 9'd7;
    assign new_pages = h_round[8:3];
    assign col_inc   = r_col + 8'd1;
    assign page_inc  = r_page + 6'd1;

    assign o_job.px   = px_sum[COORD_BITS-1:0];
    assign o_job.py0  = py_sum[COORD_BITS-1:0];
    assign o_job.bits = i_bitmap_byte;

    always_comb begin
        n_origin_x = r_origin_x;
        n_origin_y = r_origin_y;
        n_width    = r_width;
        n_pages    = r_pages;
        n_col      = r_col;
        n_page     = r_page;
        n_active   = r_active;
        o_push     = 1'b0;
        if (accept) begin
            case (i_action)
                ACT_BEGIN, ACT_NEXT: begin
                    if (i_action == ACT_BEGIN) begin
                        n_origin_x = to_coord(i_start_x);
                        n_origin_y = to_coord(i_start_y);
                    end else begin
                        n_origin_x = nx_sum[COORD_BITS-1:0];
                    end
                    n_width  = i_image_width;
                    n_pages  = new_pages;
                    n_col    = '0;
                    n_page   = '0;
                    n_active = (i_image_width != 8'd0) && (new_pages != 6'd0);
                end
                ACT_BYTE: begin
                    if (r_active) begin
                        o_push = (i_bitmap_byte != 8'd0);
                        n_col  = col_inc;
                        if (col_inc >= r_width) begin
                            n_col  = '0;
                            n_page = page_inc;
                            if (page_inc >= r_pages) begin
                                n_active = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= '0;
            r_pages    <= '0;
            r_col      <= '0;
            r_page     <= '0;
            r_active   <= 1'b0;
        end else begin
            r_origin_x <= n_origin_x;
            r_origin_y <= n_origin_y;
            r_width    <= n_width;
            r_pages    <= n_pages;
            r_col      <= n_col;
            r_page     <= n_page;
            r_active   <= n_active;
        end
    end

endmodule

// ===== rtl/pbb_back.sv =====
// Back end: turns each queued byte into one pixel word per set bit.
`timescale 1ns / 1ps
`include "page_bitmap_blitter_assert.svh"
module pbb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fifo_valid,
    input  pbb_pkg::t_job i_job,
    output logic          o_pop,
    input  logic [15:0]   i_pixel_color,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pbb_pkg::t_pix o_pixel_x,
    output pbb_pkg::t_pix o_pixel_y,
    output logic [15:0]   o_color,
    output logic          o_last
);
    import pbb_pkg::*;

    localparam int SUM_W = COORD_BITS + 1;

    // Index of the highest set bit, which is the uppermost remaining pixel.
    function automatic logic [2:0] top_bit(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    logic        r_job_valid, n_job_valid;
    logic [7:0]  r_bits,      n_bits;
    t_coord      r_px,        n_px;
    t_coord      r_py0,       n_py0;

    logic        r_out_valid, n_out_valid;
    t_pix        r_out_x,     n_out_x;
    t_pix        r_out_y,     n_out_y;
    logic [15:0] r_out_color, n_out_color;
    logic        r_out_last,  n_out_last;

    logic             out_free, emit, job_done;
    logic [2:0]       idx;
    logic [2:0]       row_off;
    logic [7:0]       remaining;
    logic [SUM_W-1:0] py_sum;

    assign out_free  = !r_out_valid || i_out_ready;
    assign emit      = r_job_valid && out_free;
    assign idx       = top_bit(r_bits);
    assign remaining = r_bits & ~(8'd1 << idx);
    // Row offset within the page is 7 minus the bit index.
    assign row_off   = ~idx;
    assign py_sum    = {1'b0, r_py0} + {{(SUM_W - 3){1'b0}}, row_off};
    assign job_done  = !r_job_valid || (emit && (remaining == 8'd0));
    assign o_pop     = job_done && i_fifo_valid;

    always_comb begin
        n_job_valid = r_job_valid;
        n_bits      = r_bits;
        n_px        = r_px;
        n_py0       = r_py0;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_x     = to_pix(r_px);
            n_out_y     = to_pix(py_sum[COORD_BITS-1:0]);
            n_out_color = i_pixel_color;
            n_out_last  = (remaining == 8'd0);
            n_bits      = remaining;
            n_job_valid = (remaining != 8'd0);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_job_valid = 1'b1;
            n_bits      = i_job.bits;
            n_px        = i_job.px;
            n_py0       = i_job.py0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits      <= n_bits;
        r_px        <= n_px;
        r_py0       <= n_py0;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_out_x;
    assign o_pixel_y   = r_out_y;
    assign o_color     = r_out_color;
    assign o_last      = r_out_last;

    `PBB_ASSERT_IMPL(a_job_has_bits, r_job_valid, r_bits != 8'd0, "active job with no bits left")
    `PBB_ASSERT_IMPL(a_pop_nonempty, o_pop, i_fifo_valid, "pop from an empty queue")
    `PBB_ASSERT_IMPL(a_mid_byte_job, r_out_valid && !r_out_last, r_job_valid, "byte cut short")

endmodule

// ===== rtl/page_bitmap_blitter.sv =====
// Top level of the page bitmap blitter: ports, color register and wiring.
`timescale 1ns / 1ps

// The blitter turns a page-organised monochrome bitmap into pixel writes.
// Each input word carries an action in s_axis_tuser: begin opens an image at
// the given origin with a width and a height, next glyph opens an image right
// of the previous one plus one blank column, and a byte word supplies one
// column of one 8-row page, most significant bit at the top. Every set bit of
// an in-image byte becomes one output word with its column, row and the
// current color; tlast marks the final pixel of a byte. Zero bytes and bytes
// past the end of the image give no output. A byte with n set bits holds the
// pixel stage until all n of its pixels are out, one pixel per cycle while the
// output is not stalled; the front accepts one word per cycle as long as its
// four-entry job queue has room, so begin words and empty bytes pass while
// earlier pixels are still draining.
// The color register may only be written while no pixels are pending.
module page_bitmap_blitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,      // pixel_color
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_x[9:0], start_y[19:10], image_width[27:20], image_height[35:28],
    // bitmap_byte[43:36], zero fill[47:44]
    input  logic [47:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,    // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x[9:0], pixel_y[19:10], color[35:20], zero fill[39:36]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast     // last pixel of the byte
);
    import pbb_pkg::*;

    logic [15:0] r_pixel_color;

    logic  fifo_push, fifo_full, fifo_pop, fifo_valid;
    t_job  push_job, pop_job;
    t_pix  pixel_x, pixel_y;
    logic [15:0] color;

    // The color register is always ready; it resets to white.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_color <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            r_pixel_color <= i_cfg_data;
        end
    end

    pbb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_action       (t_action'(s_axis_tuser)),
        .i_start_x      (s_axis_tdata[9:0]),
        .i_start_y      (s_axis_tdata[19:10]),
        .i_image_width  (s_axis_tdata[27:20]),
        .i_image_height (s_axis_tdata[35:28]),
        .i_bitmap_byte  (s_axis_tdata[43:36]),
        .o_push         (fifo_push),
        .o_job          (push_job),
        .i_full         (fifo_full)
    );

    pbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_job   (push_job),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_job   (pop_job)
    );

    pbb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_valid  (fifo_valid),
        .i_job         (pop_job),
        .o_pop         (fifo_pop),
        .i_pixel_color (r_pixel_color),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_color       (color),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, color, pixel_y, pixel_x};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the page bitmap blitter stream block.
`timescale 1ns / 1ps

module testbench;
    import pbb_pkg::*;

    // The package names only the three defined actions; this one is ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Cycles with no handshake anywhere before the run is called hung.
    localparam int QUIET_LIMIT = 4000;
    // Settling time once the last pixel is out.
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_pix        x;
        t_pix        y;
        logic [15:0] color;
        logic        last;
    } t_pixel;

    // Predicts the pixel writes of every accepted word and checks what comes out.
    class pixel_scoreboard;
        t_coord      org_x;
        t_coord      org_y;
        logic [7:0]  width_cols;
        logic [7:0]  col_idx;
        logic [5:0]  total_pages;
        logic [5:0]  page_idx;
        bit          image_open;
        logic [15:0] color;
        t_pixel      pending_pixels[$];
        int          mismatches;

        function new();
            org_x = '0;
            org_y = '0;
            width_cols = '0;
            col_idx = '0;
            total_pages = '0;
            page_idx = '0;
            image_open = 1'b0;
            color = 16'hFFFF;
            mismatches = 0;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        function void set_color(logic [15:0] c);
            color = c;
        endfunction

        function void open_image(logic [7:0] w, logic [7:0] h);
            logic [8:0] rounded;
            rounded = {1'b0, h} + 9'd7;
            width_cols = w;
            total_pages = rounded[8:3];
            col_idx = '0;
            page_idx = '0;
            image_open = (width_cols != 0) && (total_pages != 0);
        endfunction

        function void note_word(logic [1:0] act, logic [47:0] data);
            logic [7:0] bits;
            t_coord     px;
            t_coord     py0;
            t_pixel     pix;
            int         set_count;
            int         emitted;
            bits = data[43:36];
            case (act)
                ACT_BEGIN: begin
                    org_x = data[9:0];
                    org_y = data[19:10];
                    open_image(data[27:20], data[35:28]);
                end
                ACT_NEXT: begin
                    // The new glyph starts one blank column right of the old one.
                    org_x = t_coord'(org_x + width_cols + 1);
                    open_image(data[27:20], data[35:28]);
                end
                ACT_BYTE: begin
                    if (image_open) begin
                        px = org_x + col_idx;
                        py0 = org_y + {page_idx, 3'b000};
                        set_count = $countones(bits);
                        emitted = 0;
                        for (int b = 0; b < 8; b++) begin
                            if (bits[7 - b]) begin
                                emitted++;
                                pix.x = px;
                                pix.y = t_pix'(py0 + t_coord'(b));
                                pix.color = color;
                                pix.last = (emitted == set_count);
                                pending_pixels.push_back(pix);
                            end
                        end
                        col_idx = col_idx + 8'd1;
                        if (col_idx >= width_cols) begin
                            col_idx = '0;
                            page_idx = page_idx + 6'd1;
                            if (page_idx >= total_pages) begin
                                image_open = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_pixel(logic [39:0] data, logic last_flag);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                flag_error($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
                                     data[9:0], data[19:10], data[35:20], last_flag));
                return;
            end
            want = pending_pixels.pop_front();
            if (data[9:0] !== want.x || data[19:10] !== want.y ||
                data[35:20] !== want.color || last_flag !== want.last) begin
                flag_error($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%h last=%b,",
                                      " got x=%0d y=%0d color=%h last=%b"},
                    want.x, want.y, want.color, want.last,
                    data[9:0], data[19:10], data[35:20], last_flag));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // start_x, start_y, image_width, image_height, bitmap_byte
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;     // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // pixel_x, pixel_y, color
    logic        m_axis_tlast;          // last pixel of the byte

    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              quiet_cycles = 0;
    pixel_scoreboard sb = new();

    page_bitmap_blitter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The pixel side stalls at random with the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watches all three channels, feeds the scoreboard and guards against a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_word(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_pixel(m_axis_tdata, m_axis_tlast);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_color(i_cfg_data);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [47:0] pack_word(logic [9:0] sx, logic [9:0] sy,
                                              logic [7:0] w, logic [7:0] h, logic [7:0] b);
        return {4'b0000, b, h, w, sy, sx};
    endfunction

    // A bitmap byte with junk in the fields the block ignores for bytes.
    function automatic logic [47:0] byte_word(logic [7:0] b);
        return pack_word(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                         8'($urandom_range(255)), 8'($urandom_range(255)), b);
    endfunction

    function automatic logic [47:0] image_word(logic [9:0] sx, logic [9:0] sy,
                                               logic [7:0] w, logic [7:0] h);
        return pack_word(sx, sy, w, h, 8'($urandom_range(255)));
    endfunction

    // Offers one word, with random idle cycles first, and returns once it is taken.
    task automatic push_word(input logic [1:0] act, input logic [47:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= data;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [15:0] c);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly complete images with random content; some are cut short, some
    // overrun their end, a few are huge and only partly filled, plus noise.
    task automatic run_images(input int count);
        int         done;
        int         nbytes;
        int         pick;
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] b;
        logic [1:0] act;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 6) begin
                push_word(ACT_UNUSED,
                          pack_word(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                    8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255))));
            end else begin
                w = ($urandom_range(15) == 0) ? 8'($urandom_range(255, 1))
                                              : 8'($urandom_range(6, 1));
                h = ($urandom_range(15) == 0) ? 8'($urandom_range(255, 1))
                                              : 8'($urandom_range(24, 1));
                act = $urandom_range(1) ? ACT_BEGIN : ACT_NEXT;
                push_word(act, image_word(10'($urandom_range(1023)),
                                          10'($urandom_range(1023)), w, h));
                done++;
                nbytes = w * ((h + 7) / 8);
                if (nbytes > 24) begin
                    nbytes = $urandom_range(24, 1);
                end else begin
                    pick = $urandom_range(9);
                    if (pick == 0) begin
                        nbytes = $urandom_range(nbytes - 1, 0);
                    end else if (pick == 1) begin
                        nbytes = nbytes + $urandom_range(2, 1);
                    end
                end
                for (int i = 0; i < nbytes; i++) begin
                    pick = $urandom_range(9);
                    b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
                    push_word(ACT_BYTE, byte_word(b));
                    done++;
                end
            end
        end
    endtask

    initial begin
        logic [15:0] phase_color [4];
        int          idle_pct [4];
        int          stall_pct [4];
        phase_color = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5AA5};
        phase_color[2] = 16'($urandom_range(65535));
        idle_pct = '{0, 72, 0, 8};
        stall_pct = '{0, 0, 72, 8};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the color still at its reset value.
        push_word(ACT_BYTE, byte_word(8'hFF));                     // no image open yet
        push_word(ACT_UNUSED, pack_word(10'h3FF, 10'h3FF, 8'hFF, 8'hFF, 8'hFF));
        push_word(ACT_NEXT, image_word(10'd500, 10'd500, 8'd2, 8'd8)); // starts at x = 1
        push_word(ACT_BYTE, byte_word(8'hFF));
        push_word(ACT_BYTE, byte_word(8'h00));
        push_word(ACT_BYTE, byte_word(8'h81));                     // past the end
        // Two pages near the far corner so that both coordinates wrap.
        push_word(ACT_BEGIN, image_word(10'd1023, 10'd1020, 8'd3, 8'd9));
        push_word(ACT_BYTE, byte_word(8'h80));
        push_word(ACT_BYTE, byte_word(8'h01));
        push_word(ACT_BYTE, byte_word(8'hAA));
        push_word(ACT_BYTE, byte_word(8'h55));
        push_word(ACT_BYTE, byte_word(8'hFF));
        push_word(ACT_BYTE, byte_word(8'h00));
        push_word(ACT_BYTE, byte_word(8'hFF));                     // past the end
        // Empty images leave no image open.
        push_word(ACT_BEGIN, image_word(10'd10, 10'd10, 8'd0, 8'd5));
        push_word(ACT_BYTE, byte_word(8'hFF));
        push_word(ACT_BEGIN, image_word(10'd10, 10'd10, 8'd5, 8'd0));
        push_word(ACT_BYTE, byte_word(8'hFF));
        // Largest image, then a glyph placed after it.
        push_word(ACT_BEGIN, image_word(10'd0, 10'd0, 8'd255, 8'd255));
        push_word(ACT_BYTE, byte_word(8'hFF));
        push_word(ACT_BYTE, byte_word(8'h7E));
        push_word(ACT_NEXT, image_word(10'd0, 10'd0, 8'd1, 8'd1));
        push_word(ACT_BYTE, byte_word(8'h01));
        push_word(ACT_BYTE, byte_word(8'h80));                     // past the end

        for (int p = 0; p < 4; p++) begin
            write_color(phase_color[p]);
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            run_images(110);
        end

        wait_drained();
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pbb_pkg.sv
rtl/pbb_fifo.sv
rtl/pbb_front.sv
rtl/pbb_back.sv
rtl/page_bitmap_blitter.sv
dv/testbench.sv
